// ===== rtl/assert_macros.svh =====
// Concurrent assertion helpers used by the RTL controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge outside of reset.
`define HPQ_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define HPQ_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== rtl/hpq_pkg.sv =====
package hpq_pkg;

   localparam int KEY_W            = 32;
   localparam int TOTAL_W          = 11;
   localparam int DEFAULT_CAPACITY = 1024;

   typedef enum logic {
      OP_PUSH = 1'b0,
      OP_POP  = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   // Command broadcast to every cell of the sorted row
   typedef struct packed {
      logic                    push;
      logic                    pop;
      logic signed [KEY_W-1:0] key;
   } cmd_type;

endpackage

// ===== rtl/hpq_if.sv =====
interface hpq_req_if import hpq_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic                    opcode;
   logic signed [KEY_W-1:0] key_value;

   modport source (output valid, output opcode, output key_value, input ready);
   modport sink   (input valid, input opcode, input key_value, output ready);
endinterface

interface hpq_rsp_if import hpq_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [KEY_W-1:0] max_key;
   logic                    heap_empty;
   logic [TOTAL_W-1:0]      entry_total;
   logic [1:0]              status;

   modport source (output valid, output max_key, output heap_empty, output entry_total,
                   output status, input ready);
   modport sink   (input valid, input max_key, input heap_empty, input entry_total,
                   input status, output ready);
endinterface

// ===== rtl/hpq_cell.sv =====
module hpq_cell import hpq_pkg::*; #(
   parameter int CNT_W = $clog2(DEFAULT_CAPACITY + 1),
   parameter int IDX   = 0
) (
   input  logic                    clock,
   input  cmd_type                 cmd,
   input  logic [CNT_W-1:0]        count,
   input  logic signed [KEY_W-1:0] left_data,
   input  logic                    left_keep,
   input  logic signed [KEY_W-1:0] right_data,
   output logic signed [KEY_W-1:0] data,
   output logic                    keep
);

   logic signed [KEY_W-1:0] data_ff;
   logic signed [KEY_W-1:0] data_in;
   logic                    occupied;

   // Row is sorted largest first; keep marks the prefix that stays put on a push.
   assign occupied = count > CNT_W'(IDX);
   assign keep     = occupied && (data_ff >= cmd.key);
   assign data     = data_ff;

   always_comb begin
      data_in = data_ff;
      if (cmd.pop) begin
         data_in = right_data;
      end else if (cmd.push && !keep) begin
         data_in = left_keep ? cmd.key : left_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule

// ===== rtl/hpq_ctrl.sv =====
`include "assert_macros.svh"

module hpq_ctrl import hpq_pkg::*; #(
   parameter int CAPACITY = DEFAULT_CAPACITY,
   parameter int CNT_W    = $clog2(DEFAULT_CAPACITY + 1)
) (
   input  logic                    clock,
   input  logic                    reset,
   hpq_req_if.sink                 req_chan,
   hpq_rsp_if.source               rsp_chan,
   input  logic signed [KEY_W-1:0] head_data,
   output cmd_type                 cmd,
   output logic [CNT_W-1:0]        count
);

   logic [CNT_W-1:0]        count_ff, count_in;
   logic                    busy_ff, busy_in;
   status_type              pend_status_ff, pend_status_in;
   logic                    out_valid_ff, out_valid_in;
   logic signed [KEY_W-1:0] out_max_ff, out_max_in;
   logic                    out_empty_ff, out_empty_in;
   logic [TOTAL_W-1:0]      out_total_ff, out_total_in;
   status_type              out_status_ff, out_status_in;

   logic accept;
   logic capture;
   logic is_pop;
   logic is_full;
   logic is_empty;

   // busy: state already updated, result not yet in the output register
   assign capture  = busy_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !busy_ff || capture;
   assign accept   = req_chan.valid && req_chan.ready;
   assign is_pop   = req_chan.opcode == OP_POP;
   assign is_full  = count_ff == CNT_W'(CAPACITY);
   assign is_empty = count_ff == '0;

   assign cmd.push = accept && !is_pop && !is_full;
   assign cmd.pop  = accept && is_pop && !is_empty;
   assign cmd.key  = req_chan.key_value;
   assign count    = count_ff;

   always_comb begin
      count_in       = count_ff;
      busy_in        = busy_ff;
      pend_status_in = pend_status_ff;
      if (cmd.push) begin
         count_in = count_ff + 1'b1;
      end else if (cmd.pop) begin
         count_in = count_ff - 1'b1;
      end
      if (capture) begin
         busy_in = 1'b0;
      end
      if (accept) begin
         busy_in = 1'b1;
         if (!is_pop && is_full) begin
            pend_status_in = STATUS_FULL;
         end else if (is_pop && is_empty) begin
            pend_status_in = STATUS_EMPTY;
         end else begin
            pend_status_in = STATUS_OK;
         end
      end
   end

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_max_in    = out_max_ff;
      out_empty_in  = out_empty_ff;
      out_total_in  = out_total_ff;
      out_status_in = out_status_ff;
      if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
      if (capture) begin
         out_valid_in  = 1'b1;
         out_max_in    = is_empty ? '0 : head_data;
         out_empty_in  = is_empty;
         out_total_in  = TOTAL_W'(count_ff);
         out_status_in = pend_status_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_status_ff <= pend_status_in;
      out_max_ff     <= out_max_in;
      out_empty_ff   <= out_empty_in;
      out_total_ff   <= out_total_in;
      out_status_ff  <= out_status_in;
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.max_key     = out_max_ff;
   assign rsp_chan.heap_empty  = out_empty_ff;
   assign rsp_chan.entry_total = out_total_ff;
   assign rsp_chan.status      = out_status_ff;

   `HPQ_ASSERT(count_in_range, count_ff <= CNT_W'(CAPACITY), "entry count above capacity")
   `HPQ_ASSERT(push_grows, cmd.push |=> count_ff == $past(count_ff) + 1'b1, "push lost")
   `HPQ_ASSERT(refused_holds, (accept && !cmd.push && !cmd.pop) |=> $stable(count_ff),
      "refused item changed the count")
   `HPQ_ASSERT(result_waits, (busy_ff && !capture) |=> busy_ff, "pending result dropped")
   `HPQ_ASSERT_ALWAYS(one_cmd, !(cmd.push && cmd.pop), "push and pop together")

endmodule

// ===== rtl/max_heap_priority_queue.sv =====
// Channel  | Dir | Fields                                       | Accepted when
// ---------+-----+----------------------------------------------+-----------------
// req_chan | in  | opcode, key_value                            | valid && ready
// rsp_chan | out | max_key, heap_empty, entry_total, status     | valid && ready
//
// One item per cycle unless a stalled result holds requests: the sorted cells shift on the
// edge that accepts a push or a pop. The result is then registered once the output
// register is free, and holds until taken; a stalled result admits at most one more item.
// Synchronous reset empties the queue at once; cell contents are not cleared.
module max_heap_priority_queue import hpq_pkg::*; #(
   parameter int CAPACITY = DEFAULT_CAPACITY
) (
   input  logic      clock,
   input  logic      reset,
   hpq_req_if.sink   req_chan,
   hpq_rsp_if.source rsp_chan
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   cmd_type                 cmd;
   logic [CNT_W-1:0]        count;
   logic signed [KEY_W-1:0] cell_data [CAPACITY];
   logic                    cell_keep [CAPACITY];

   hpq_ctrl #(
      .CAPACITY (CAPACITY),
      .CNT_W    (CNT_W)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .head_data (cell_data[0]),
      .cmd       (cmd),
      .count     (count)
   );

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [KEY_W-1:0] left_data;
      logic                    left_keep;
      logic signed [KEY_W-1:0] right_data;

      if (i == 0) begin : g_head
         assign left_data = '0;
         assign left_keep = 1'b1;
      end else begin : g_body
         assign left_data = cell_data[i-1];
         assign left_keep = cell_keep[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign right_data = cell_data[i];
      end else begin : g_next
         assign right_data = cell_data[i+1];
      end

      hpq_cell #(
         .CNT_W (CNT_W),
         .IDX   (i)
      ) u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .count      (count),
         .left_data  (left_data),
         .left_keep  (left_keep),
         .right_data (right_data),
         .data       (cell_data[i]),
         .keep       (cell_keep[i])
      );
   end

endmodule

// ===== bench/max_heap_priority_queue_tb.sv =====
`timescale 1ns / 1ps

module max_heap_priority_queue_tb;
   import hpq_pkg::*;

   localparam int CAPACITY    = DEFAULT_CAPACITY;
   localparam int ITEM_TARGET = 1550;
   localparam int CYCLE_LIMIT = 400000;

   localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7fff_ffff;
   localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;

   typedef struct packed {
      logic signed [KEY_W-1:0] max_key;
      logic                    heap_empty;
      logic [TOTAL_W-1:0]      entry_total;
      status_type              status;
   } heap_answer_type;

   // Shadow heap: mirrors the queue contents and holds the answers still owed
   class heap_tracker;
      logic signed [KEY_W-1:0] keys [CAPACITY];
      int                      entry_count;
      heap_answer_type         owed [$];
      int                      errors;
      int                      pushes, pops, full_refusals, empty_refusals, peak;

      function void note_item(opcode_type op, logic signed [KEY_W-1:0] key);
         heap_answer_type         ans;
         logic signed [KEY_W-1:0] tmp;
         int                      node, up, lft, rgt, pick;
         ans.status = STATUS_OK;
         if (op == OP_PUSH) begin
            if (entry_count >= CAPACITY) begin
               ans.status = STATUS_FULL;
               full_refusals++;
            end else begin
               pushes++;
               keys[entry_count] = key;
               entry_count++;
               node = entry_count - 1;
               while (node > 0) begin
                  up = (node - 1) / 2;
                  if (!(keys[node] > keys[up])) break;
                  tmp = keys[node];
                  keys[node] = keys[up];
                  keys[up] = tmp;
                  node = up;
               end
            end
         end else begin
            if (entry_count == 0) begin
               ans.status = STATUS_EMPTY;
               empty_refusals++;
            end else begin
               pops++;
               entry_count--;
               keys[0] = keys[entry_count];
               node = 0;
               while (1) begin
                  lft = 2 * node + 1;
                  rgt = 2 * node + 2;
                  if (lft >= entry_count) break;
                  pick = lft;
                  // left child wins a tie
                  if (rgt < entry_count && keys[rgt] > keys[lft]) pick = rgt;
                  if (!(keys[pick] > keys[node])) break;
                  tmp = keys[pick];
                  keys[pick] = keys[node];
                  keys[node] = tmp;
                  node = pick;
               end
            end
         end
         if (entry_count > peak) peak = entry_count;
         ans.max_key     = (entry_count == 0) ? '0 : keys[0];
         ans.heap_empty  = (entry_count == 0);
         ans.entry_total = entry_count[TOTAL_W-1:0];
         owed.push_back(ans);
      endfunction

      function void check_item(heap_answer_type got);
         heap_answer_type want;
         if (owed.size() == 0) begin
            $display("%0t: result with no item pending: max_key %0d total %0d status %0d",
                     $time, got.max_key, got.entry_total, got.status);
            errors++;
            return;
         end
         want = owed.pop_front();
         if (got.max_key !== want.max_key) begin
            $display("%0t: max_key expected %0d actual %0d", $time, want.max_key, got.max_key);
            errors++;
         end
         if (got.heap_empty !== want.heap_empty) begin
            $display("%0t: heap_empty expected %0b actual %0b",
                     $time, want.heap_empty, got.heap_empty);
            errors++;
         end
         if (got.entry_total !== want.entry_total) begin
            $display("%0t: entry_total expected %0d actual %0d",
                     $time, want.entry_total, got.entry_total);
            errors++;
         end
         if (got.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
            errors++;
         end
      endfunction
   endclass

   logic            clock;
   logic            reset;
   hpq_req_if       req_chan ();
   hpq_rsp_if       rsp_chan ();
   heap_tracker     tracker = new;
   heap_answer_type seen;
   int              cycle_count;
   int              items_sent;
   int              send_left;
   bit              send_calm;

   max_heap_priority_queue u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("max_heap_priority_queue: mismatch");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         seen.max_key     = rsp_chan.max_key;
         seen.heap_empty  = rsp_chan.heap_empty;
         seen.entry_total = rsp_chan.entry_total;
         seen.status      = status_type'(rsp_chan.status);
         tracker.check_item(seen);
      end
   end

   // mostly full-range keys, some extremes, some narrow range to force ties
   function automatic logic signed [KEY_W-1:0] pick_key();
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 4))
               0: return KEY_MAX;
               1: return KEY_MIN;
               2: return '0;
               3: return -1;
               default: return 1;
            endcase
         end
         1, 2: return $urandom_range(0, 16) - 8;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_item(input opcode_type op, input logic signed [KEY_W-1:0] key);
      int gap;
      if (send_left == 0) begin
         send_calm = ($urandom_range(0, 2) == 0);
         send_left = $urandom_range(16, 64);
      end
      send_left--;
      gap = send_calm ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.opcode    <= op;
      req_chan.key_value <= key;
      do @(posedge clock); while (!req_chan.ready);
      tracker.note_item(op, key);
      items_sent++;
   endtask

   task automatic send_mix(input int count, input int push_pct);
      repeat (count)
         send_item(($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP, pick_key());
   endtask

   // result side: random stalls with calm stretches
   initial begin : drain
      int stall;
      int left;
      bit calm;
      rsp_chan.ready <= 1'b0;
      left = 0;
      calm = 0;
      do @(posedge clock); while (reset);
      forever begin
         if (left == 0) begin
            calm = ($urandom_range(0, 2) == 0);
            left = $urandom_range(16, 64);
         end
         left--;
         stall = calm ? 0 : $urandom_range(0, 15);
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
      end
   end

   initial begin
      cycle_count        = 0;
      items_sent         = 0;
      send_left          = 0;
      send_calm          = 0;
      reset              <= 1'b1;
      req_chan.valid     <= 1'b0;
      req_chan.opcode    <= OP_PUSH;
      req_chan.key_value <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: refused pop, extreme keys with a tie, drain to empty, last-entry pop
      send_item(OP_POP, KEY_MAX);
      send_item(OP_PUSH, KEY_MAX);
      send_item(OP_PUSH, KEY_MIN);
      send_item(OP_PUSH, '0);
      send_item(OP_PUSH, -1);
      send_item(OP_PUSH, 1);
      send_item(OP_PUSH, KEY_MAX);
      repeat (6) send_item(OP_POP, '0);
      send_item(OP_POP, -1);
      send_item(OP_PUSH, KEY_MIN);
      send_item(OP_POP, KEY_MIN);
      send_item(OP_PUSH, -1);
      send_item(OP_PUSH, -1);
      send_item(OP_POP, KEY_MAX);
      send_item(OP_POP, KEY_MIN);
      send_item(OP_PUSH, 32'sh5a5a_a5a5);
      send_item(OP_PUSH, 32'sha5a5_5a5a);
      send_item(OP_POP, '0);
      send_item(OP_POP, '0);

      // small heaps that empty often
      send_mix(150, 50);
      send_mix(150, 40);
      // fill to capacity, then push into a full heap
      while (tracker.entry_count < CAPACITY)
         send_item(($urandom_range(0, 99) < 97) ? OP_PUSH : OP_POP, pick_key());
      repeat (12) send_item(OP_PUSH, pick_key());
      while (items_sent < ITEM_TARGET)
         send_item(($urandom_range(0, 99) < 20) ? OP_PUSH : OP_POP, pick_key());
      req_chan.valid <= 1'b0;

      while (tracker.owed.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      $display("%0d items: %0d pushes, %0d pops, %0d refused as full, %0d refused as empty",
               items_sent, tracker.pushes, tracker.pops, tracker.full_refusals,
               tracker.empty_refusals);
      $display("peak occupancy %0d of %0d entries, %0d field errors",
               tracker.peak, CAPACITY, tracker.errors);
      if (tracker.errors == 0) begin
         $display("max_heap_priority_queue: match");
      end else begin
         $display("max_heap_priority_queue: mismatch");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/hpq_pkg.sv
rtl/hpq_if.sv
rtl/hpq_cell.sv
rtl/hpq_ctrl.sv
rtl/max_heap_priority_queue.sv
bench/max_heap_priority_queue_tb.sv
